>>> design/tfdb_pkg.sv
// Package for the timestamped frame descriptor buffer.
// Holds the beat structs, operation, status and configuration index codes, and the sequencer state type.
// No dependencies.
package tfdb_pkg;

    localparam int unsigned TimeW = 63;

    typedef enum logic [2:0] {
        FUNC_ADD     = 3'd0,
        FUNC_NEAREST = 3'd1,
        FUNC_INDEX   = 3'd2,
        FUNC_LATEST  = 3'd3,
        FUNC_POP     = 3'd4,
        FUNC_CLEAR   = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        CFG_MAX_ENTRIES = 1'd0,
        CFG_INTERVAL    = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]       func;
        logic [TimeW-1:0] now_ns;
        logic [TimeW-1:0] frame_time_ns;
        logic [31:0]      frame_handle;
        logic [15:0]      frame_width;
        logic [15:0]      frame_height;
        logic [11:0]      frame_type;
        logic [15:0]      frame_rate_q8;
        logic [TimeW-1:0] query_time_ns;
        logic [7:0]       query_index;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]       status;
        logic [TimeW-1:0] out_time_ns;
        logic [31:0]      out_handle;
        logic [15:0]      out_width;
        logic [15:0]      out_height;
        logic [11:0]      out_type;
        logic [15:0]      out_rate_q8;
        logic [4:0]       entry_count;
    } t_out_beat;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_in_beat beat;
        logic     size_bad;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_WAIT,
        S_EMIT
    } t_state;

endpackage

>>> design/tfdb_front.sv
// Front end: accepts input beats, flags empty frames, and queues commands.
// Depends on tfdb_pkg.
module tfdb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tfdb_pkg::t_in_beat i_beat,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take,
    output tfdb_pkg::t_cmd    o_cmd
);
    import tfdb_pkg::*;

    // Two-entry queue.
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].beat     <= i_beat;
            r_q[r_wp].size_bad <= (i_beat.frame_width == '0) || (i_beat.frame_height == '0);
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3;
    endproperty
    assert property (p_no_overflow) else $error("front queue count out of range");

    property p_pop_nonempty;
        @(posedge i_clk) disable iff (!i_rst_n) pop |-> r_cnt != 2'd0;
    endproperty
    assert property (p_pop_nonempty) else $error("pop from empty front queue");

    property p_full_stalls;
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt == 2'd2) |-> !push;
    endproperty
    assert property (p_full_stalls) else $error("push into full front queue");

endmodule

>>> design/tfdb_back.sv
// Back end: descriptor memory, ring pointers, add gate, nearest search, result register.
// Depends on tfdb_pkg.
module tfdb_back #(
    parameter int unsigned DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_take,
    input  tfdb_pkg::t_cmd     i_cmd,
    input  logic [4:0]         i_max_entries,
    input  logic [31:0]        i_interval,
    output logic               o_valid,
    input  logic               i_stall,
    output tfdb_pkg::t_out_beat o_beat
);
    import tfdb_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Descriptor memory: time, handle, size, type/rate.
    logic [TimeW-1:0] r_tmem [DEPTH];
    logic [31:0]      r_hmem [DEPTH];
    logic [31:0]      r_smem [DEPTH];
    logic [27:0]      r_rmem [DEPTH];

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [AW-1:0]    r_oldest, n_oldest;
    logic [CW-1:0]    r_count, n_count;
    logic [TimeW-1:0] r_last, n_last;
    logic             r_any, n_any;
    logic [CW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_best_pos, n_best_pos;
    logic [TimeW-1:0] r_best, n_best;
    logic [1:0]       r_status, n_status;
    logic             r_hit, n_hit;
    logic [AW-1:0]    r_slot, n_slot;
    logic [TimeW-1:0] r_rd_t;
    logic [31:0]      r_rd_h, r_rd_s;
    logic [27:0]      r_rd_r;
    logic             r_ovalid, n_ovalid;
    t_out_beat        r_out, n_out;

    logic             wr_en;
    logic [AW-1:0]    wr_slot;
    logic [AW-1:0]    rd_addr;
    logic [CW-1:0]    limit;
    logic [TimeW:0]   elapsed;
    logic [TimeW-1:0] diff;
    logic [TimeW-1:0] qt;

    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                              input logic [CW-1:0] pos);
        logic [AW:0] s;
        logic [AW:0] p;
        s = {1'b0, base} + {1'b0, pos[AW-1:0]};
        p = (CW > AW) ? {pos[CW-1], {AW{1'b0}}} : '0;
        s = s + p;
        if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    assign limit = (i_max_entries == 5'd0) ? CW'(1)
                 : ((32'(i_max_entries) > DEPTH) ? CW'(DEPTH) : CW'(i_max_entries));
    assign elapsed = {1'b0, r_cmd.beat.now_ns} - {1'b0, r_last};
    assign qt = r_cmd.beat.query_time_ns;
    assign diff = (r_rd_t >= qt) ? (r_rd_t - qt) : (qt - r_rd_t);

    assign o_valid = r_ovalid;
    assign o_beat  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_last   <= '0;
            r_any    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_last   <= n_last;
            r_any    <= n_any;
            r_ovalid <= n_ovalid;
        end
        r_cmd      <= n_cmd;
        r_pos      <= n_pos;
        r_best_pos <= n_best_pos;
        r_best     <= n_best;
        r_status   <= n_status;
        r_hit      <= n_hit;
        r_slot     <= n_slot;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tmem[wr_slot] <= r_cmd.beat.frame_time_ns;
            r_hmem[wr_slot] <= r_cmd.beat.frame_handle;
            r_smem[wr_slot] <= {r_cmd.beat.frame_width, r_cmd.beat.frame_height};
            r_rmem[wr_slot] <= {r_cmd.beat.frame_type, r_cmd.beat.frame_rate_q8};
        end
        r_rd_t <= r_tmem[rd_addr];
        r_rd_h <= r_hmem[rd_addr];
        r_rd_s <= r_smem[rd_addr];
        r_rd_r <= r_rmem[rd_addr];
    end

    always_comb begin
        logic [CW:0] cnt;
        logic [AW-1:0] old;
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_oldest   = r_oldest;
        n_count    = r_count;
        n_last     = r_last;
        n_any      = r_any;
        n_pos      = r_pos;
        n_best_pos = r_best_pos;
        n_best     = r_best;
        n_status   = r_status;
        n_hit      = r_hit;
        n_slot     = r_slot;
        n_ovalid   = r_ovalid && i_stall;
        n_out      = r_out;
        o_cmd_take = 1'b0;
        wr_en      = 1'b0;
        wr_slot    = slot_at(r_oldest, r_count);
        rd_addr    = r_slot;
        cnt        = '0;
        old        = r_oldest;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_cmd      = i_cmd;
                    n_pos      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // Classify and perform the state update.
                n_hit    = 1'b0;
                n_status = ST_NONE;
                n_state  = S_READ;
                case (r_cmd.beat.func)
                    FUNC_ADD: begin
                        if (r_cmd.size_bad) begin
                            n_status = ST_EMPTY;
                        end else if (r_any && (elapsed[TimeW] ||
                                     elapsed[TimeW-1:0] < {31'd0, i_interval})) begin
                            n_status = ST_SKIPPED;
                        end else begin
                            cnt = {1'b0, r_count};
                            if (r_count >= CW'(DEPTH)) begin
                                old = slot_at(old, CW'(1));
                                cnt = cnt - 1'b1;
                            end
                            wr_slot = slot_at(old, cnt[CW-1:0]);
                            wr_en   = 1'b1;
                            cnt     = cnt + 1'b1;
                            // Drop oldest beyond the limit in one step.
                            if (cnt > {1'b0, limit}) begin
                                old = slot_at(old, CW'(cnt - {1'b0, limit}));
                                cnt = {1'b0, limit};
                            end
                            n_oldest = old;
                            n_count  = cnt[CW-1:0];
                            n_last   = r_cmd.beat.now_ns;
                            n_any    = 1'b1;
                            n_status = ST_OK;
                            n_hit    = 1'b1;
                            n_slot   = wr_slot;
                        end
                    end
                    FUNC_NEAREST: begin
                        if (r_count != '0) begin
                            n_status   = ST_OK;
                            n_hit      = 1'b1;
                            n_best_pos = '0;
                            n_pos      = '0;
                            n_slot     = r_oldest;
                            rd_addr    = r_oldest;
                            n_state    = S_WAIT;
                        end
                    end
                    FUNC_INDEX: begin
                        if ({1'b0, r_cmd.beat.query_index} < 9'(r_count)) begin
                            n_status = ST_OK;
                            n_hit    = 1'b1;
                            n_slot   = slot_at(r_oldest, CW'(r_cmd.beat.query_index));
                        end
                    end
                    FUNC_LATEST: begin
                        if (r_count != '0) begin
                            n_status = ST_OK;
                            n_hit    = 1'b1;
                            n_slot   = slot_at(r_oldest, r_count - 1'b1);
                        end
                    end
                    FUNC_POP: begin
                        if (r_count != '0 && r_count >= limit) begin
                            n_status = ST_OK;
                            n_hit    = 1'b1;
                            n_slot   = r_oldest;
                            n_oldest = slot_at(r_oldest, CW'(1));
                            n_count  = r_count - 1'b1;
                        end
                    end
                    FUNC_CLEAR: begin
                        n_status = ST_OK;
                        n_count  = '0;
                        n_oldest = '0;
                    end
                    default: n_status = ST_NONE;
                endcase
            end
            S_WAIT: begin
                // r_rd_t holds the time of entry r_pos; compare and fetch the next.
                if (r_pos == '0 || diff < r_best) begin
                    n_best     = diff;
                    n_best_pos = r_pos;
                end
                if (r_pos + 1'b1 < r_count) begin
                    n_pos   = r_pos + 1'b1;
                    n_slot  = slot_at(r_oldest, r_pos + 1'b1);
                    rd_addr = n_slot;
                end else begin
                    n_slot  = slot_at(r_oldest,
                              (r_pos == '0 || diff < r_best) ? r_pos : r_best_pos);
                    n_state = S_READ;
                end
            end
            S_READ: begin
                rd_addr = r_slot;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid          = 1'b1;
                    n_out.status      = r_status;
                    n_out.out_time_ns = r_hit ? r_rd_t : '0;
                    n_out.out_handle  = r_hit ? r_rd_h : '0;
                    n_out.out_width   = r_hit ? r_rd_s[31:16] : '0;
                    n_out.out_height  = r_hit ? r_rd_s[15:0] : '0;
                    n_out.out_type    = r_hit ? r_rd_r[27:16] : '0;
                    n_out.out_rate_q8 = r_hit ? r_rd_r[15:0] : '0;
                    n_out.entry_count = 5'(r_count);
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CW'(DEPTH);
    endproperty
    assert property (p_count_bound) else $error("held count above depth");

    property p_take_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd_take |-> r_state == S_IDLE;
    endproperty
    assert property (p_take_idle) else $error("command taken while busy");

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_out));
    endproperty
    assert property (p_out_hold) else $error("stalled result changed");

endmodule

>>> design/timestamped_frame_descriptor_buffer.sv
// Top level of the timestamped frame descriptor buffer.
// Instantiates tfdb_front and tfdb_back and holds the configuration registers; uses tfdb_pkg.
//
//  Channel   Direction  Handshake              Payload
//  input     in         i_valid / o_stall      i_in_beat  (t_in_beat)
//  output    out        o_valid / i_stall      o_out_beat (t_out_beat)
//  config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// Each beat passes the back end states IDLE, SCAN, READ and EMIT; a nearest
// search walks the held entries in WAIT, as the time memory read port yields
// one stored timestamp per cycle. The front queue holds two beats, so input is
// taken while the back end works. Reset is synchronous and active low; it empties
// the queue, clears the add gate and sets max_entries to 16 and the interval to
// 33333333 ns. Stored descriptors are not cleared. A stalled result stays in the
// output register while the next beat is already in progress.
module timestamped_frame_descriptor_buffer #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tfdb_pkg::t_in_beat  i_in_beat,
    output logic                o_valid,
    input  logic                i_stall,
    output tfdb_pkg::t_out_beat o_out_beat,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import tfdb_pkg::*;

    logic [4:0]  r_max_entries;
    logic [31:0] r_interval;
    logic        cmd_valid, cmd_take;
    t_cmd        cmd;

    // Configuration registers; the user must write only while the block is idle (unenforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= 5'd16;
            r_interval    <= 32'd33333333;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAX_ENTRIES) r_max_entries <= i_cfg_data[4:0];
            else                                r_interval    <= i_cfg_data;
        end
    end

    tfdb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_beat      (i_in_beat),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take),
        .o_cmd       (cmd)
    );

    tfdb_back #(.DEPTH(DEPTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_take    (cmd_take),
        .i_cmd         (cmd),
        .i_max_entries (r_max_entries),
        .i_interval    (r_interval),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_beat        (o_out_beat)
    );

endmodule

>>> test/testbench.sv
// Self-checking testbench for the timestamped frame descriptor buffer.
// Drives directed and random beats through tfdb_pkg beat structs and checks every
// result beat against an in-bench model of the descriptor queue.
module testbench;
    import tfdb_pkg::*;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned IDLE_LIMIT = 20000;
    localparam logic [62:0] TMAX = {63{1'b1}};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    t_in_beat            i_in_beat;
    logic                o_valid;
    logic                i_stall;
    t_out_beat           o_out_beat;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [31:0]         i_cfg_data;

    timestamped_frame_descriptor_buffer #(.DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_in_beat(i_in_beat),
        .o_valid(o_valid), .i_stall(i_stall), .o_out_beat(o_out_beat),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the descriptor queue.
    logic [62:0] sh_time [DEPTH];
    logic [31:0] sh_handle [DEPTH];
    logic [15:0] sh_w [DEPTH];
    logic [15:0] sh_h [DEPTH];
    logic [11:0] sh_type [DEPTH];
    logic [15:0] sh_rate [DEPTH];
    int unsigned sh_oldest;
    int unsigned sh_count;
    logic [62:0] sh_last_add;
    bit          sh_any_add;
    logic [4:0]  sh_max_entries;
    logic [31:0] sh_interval;

    t_out_beat   pending_results[$];
    int          error_count;
    int unsigned idle_cycles;
    int          in_idle_pct;
    int          out_idle_pct;
    bit          hold_off;
    bit          hold_release;
    bit          stim_done;
    logic [62:0] clock_ns;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned queue_limit();
        if (sh_max_entries == 0) return 1;
        if (sh_max_entries > DEPTH) return DEPTH;
        return sh_max_entries;
    endfunction

    function automatic t_out_beat descriptor_at(t_status st, int slot);
        t_out_beat r;
        r = '0;
        r.status = st;
        if (slot >= 0) begin
            r.out_time_ns = sh_time[slot];
            r.out_handle  = sh_handle[slot];
            r.out_width   = sh_w[slot];
            r.out_height  = sh_h[slot];
            r.out_type    = sh_type[slot];
            r.out_rate_q8 = sh_rate[slot];
        end
        r.entry_count = sh_count[4:0];
        return r;
    endfunction

    function automatic void drop_oldest_entry();
        if (sh_count > 0) begin
            sh_oldest = (sh_oldest + 1) % DEPTH;
            sh_count--;
        end
    endfunction

    // Applies one operation to the shadow queue and returns the expected result.
    function automatic t_out_beat apply_operation(t_in_beat b);
        int unsigned lim;
        int unsigned slot;
        int unsigned best_pos;
        logic [62:0] best;
        logic [62:0] gap;
        logic [62:0] t;
        lim = queue_limit();
        case (b.func)
            FUNC_ADD: begin
                if (b.frame_width == 0 || b.frame_height == 0)
                    return descriptor_at(ST_EMPTY, -1);
                if (sh_any_add && (b.now_ns < sh_last_add ||
                        64'(b.now_ns - sh_last_add) < 64'(sh_interval)))
                    return descriptor_at(ST_SKIPPED, -1);
                if (sh_count >= DEPTH) drop_oldest_entry();
                slot = (sh_oldest + sh_count) % DEPTH;
                sh_time[slot]   = b.frame_time_ns;
                sh_handle[slot] = b.frame_handle;
                sh_w[slot]      = b.frame_width;
                sh_h[slot]      = b.frame_height;
                sh_type[slot]   = b.frame_type;
                sh_rate[slot]   = b.frame_rate_q8;
                sh_count++;
                while (sh_count > lim) drop_oldest_entry();
                sh_last_add = b.now_ns;
                sh_any_add  = 1'b1;
                return descriptor_at(ST_OK, (sh_oldest + sh_count - 1) % DEPTH);
            end
            FUNC_NEAREST: begin
                if (sh_count == 0) return descriptor_at(ST_NONE, -1);
                best = '0;
                best_pos = 0;
                for (int unsigned i = 0; i < sh_count; i++) begin
                    t = sh_time[(sh_oldest + i) % DEPTH];
                    gap = (t >= b.query_time_ns) ? t - b.query_time_ns
                                                 : b.query_time_ns - t;
                    // Strictly smaller only, so the older entry keeps a tie.
                    if (i == 0 || gap < best) begin
                        best = gap;
                        best_pos = i;
                    end
                end
                return descriptor_at(ST_OK, (sh_oldest + best_pos) % DEPTH);
            end
            FUNC_INDEX: begin
                if (b.query_index >= sh_count) return descriptor_at(ST_NONE, -1);
                return descriptor_at(ST_OK, (sh_oldest + b.query_index) % DEPTH);
            end
            FUNC_LATEST: begin
                if (sh_count == 0) return descriptor_at(ST_NONE, -1);
                return descriptor_at(ST_OK, (sh_oldest + sh_count - 1) % DEPTH);
            end
            FUNC_POP: begin
                if (sh_count == 0 || sh_count < lim) return descriptor_at(ST_NONE, -1);
                slot = sh_oldest;
                drop_oldest_entry();
                return descriptor_at(ST_OK, slot);
            end
            FUNC_CLEAR: begin
                sh_count  = 0;
                sh_oldest = 0;
                return descriptor_at(ST_OK, -1);
            end
            default: return descriptor_at(ST_NONE, -1);
        endcase
    endfunction

    // Sends one beat, waiting as long as the block stalls it. When a fixed
    // result is given, it is checked against the model's prediction as well.
    // Valid stays high after the beat so the next one can follow directly.
    task automatic send_beat(t_in_beat b, bit has_fixed, t_out_beat fixed);
        t_out_beat r;
        while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_beat <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = apply_operation(b);
        if (has_fixed && r !== fixed) begin
            $error("directed row: expected %h, model gives %h", fixed, r);
            error_count++;
        end
        pending_results.insert(pending_results.size(), has_fixed ? fixed : r);
        @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx == CFG_MAX_ENTRIES) sh_max_entries = value[4:0];
        else sh_interval = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drops valid, waits until every expected result has arrived, then lets
    // the back end settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3 * DEPTH) @(negedge i_clk);
    endtask

    function automatic t_in_beat random_beat();
        t_in_beat b;
        logic [319:0] raw;
        int unsigned pick;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        b = raw[$bits(t_in_beat)-1:0];
        pick = $urandom_range(99);
        if (pick < 45) b.func = FUNC_ADD;
        else if (pick < 60) b.func = FUNC_NEAREST;
        else if (pick < 72) b.func = FUNC_INDEX;
        else if (pick < 82) b.func = FUNC_LATEST;
        else if (pick < 93) b.func = FUNC_POP;
        else if (pick < 96) b.func = FUNC_CLEAR;
        else b.func = 3'(6 + $urandom_range(1));
        // Mostly a clock that moves forward past the gate; sometimes backward.
        if ($urandom_range(9) != 0) begin
            clock_ns = clock_ns + 63'($urandom_range(3)) * 63'(sh_interval) + 63'($urandom);
            b.now_ns = clock_ns;
        end else begin
            b.now_ns = clock_ns >> 1;
        end
        if ($urandom_range(9) != 0) begin
            b.frame_width  = b.frame_width  | 16'd1;
            b.frame_height = b.frame_height | 16'd1;
        end
        if ($urandom_range(3) != 0) begin
            b.frame_time_ns = clock_ns + 63'($urandom_range(1000));
            b.query_time_ns = clock_ns + 63'($urandom_range(4000)) - 63'(2000);
        end
        if ($urandom_range(3) != 0) b.query_index = 8'($urandom_range(17));
        return b;
    endfunction

    // Result side: random stall, the long hold-off, and the field checks.
    always @(negedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else i_stall <= (out_idle_pct > 0) && ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation: %h", o_out_beat);
                error_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_out_beat.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status,
                           o_out_beat.status);
                    error_count++;
                end
                if (o_out_beat.out_time_ns !== want.out_time_ns) begin
                    $error("out_time_ns: expected %0d, actual %0d", want.out_time_ns,
                           o_out_beat.out_time_ns);
                    error_count++;
                end
                if (o_out_beat.out_handle !== want.out_handle) begin
                    $error("out_handle: expected %0h, actual %0h", want.out_handle,
                           o_out_beat.out_handle);
                    error_count++;
                end
                if (o_out_beat.out_width !== want.out_width) begin
                    $error("out_width: expected %0d, actual %0d", want.out_width,
                           o_out_beat.out_width);
                    error_count++;
                end
                if (o_out_beat.out_height !== want.out_height) begin
                    $error("out_height: expected %0d, actual %0d", want.out_height,
                           o_out_beat.out_height);
                    error_count++;
                end
                if (o_out_beat.out_type !== want.out_type) begin
                    $error("out_type: expected %0h, actual %0h", want.out_type,
                           o_out_beat.out_type);
                    error_count++;
                end
                if (o_out_beat.out_rate_q8 !== want.out_rate_q8) begin
                    $error("out_rate_q8: expected %0d, actual %0d", want.out_rate_q8,
                           o_out_beat.out_rate_q8);
                    error_count++;
                end
                if (o_out_beat.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d", want.entry_count,
                           o_out_beat.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The long receiver hold-off, counted here so the sender keeps offering.
    initial begin
        wait (hold_release);
        hold_off = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_off = 1'b0;
    end

    typedef struct {
        t_in_beat  beat;
        bit        has_fixed;
        t_out_beat fixed;
    } t_row;

    initial begin
        t_row rows[$];
        t_row row;
        t_in_beat b;
        t_out_beat f;
        int unsigned interval_pick;

        i_rst_n = 1'b0; i_valid = 1'b0; i_in_beat = '0; i_stall = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = 1'b0; i_cfg_data = '0;
        error_count = 0; idle_cycles = 0; in_idle_pct = 0; out_idle_pct = 0;
        hold_off = 1'b0; hold_release = 1'b0; stim_done = 1'b0;
        sh_oldest = 0; sh_count = 0; sh_last_add = '0; sh_any_add = 1'b0;
        sh_max_entries = 5'd16; sh_interval = 32'd33333333; clock_ns = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sh_time[i] = '0; sh_handle[i] = '0; sh_w[i] = '0; sh_h[i] = '0;
            sh_type[i] = '0; sh_rate[i] = '0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table. Rows with a fixed result are the obvious ones; the
        // rest rely on the model alone.
        b = '0; b.func = FUNC_LATEST; f = '0; f.status = ST_NONE;
        row = '{b, 1, f}; rows.insert(rows.size(), row);
        b.func = FUNC_NEAREST; row = '{b, 1, f}; rows.insert(rows.size(), row);
        b.func = FUNC_INDEX; row = '{b, 1, f}; rows.insert(rows.size(), row);
        b.func = FUNC_POP; row = '{b, 1, f}; rows.insert(rows.size(), row);
        // Empty frame, then an add of all-ones descriptor fields at the largest
        // timestamp.
        b = '0; b.func = FUNC_ADD; b.frame_width = 16'hFFFF; f = '0; f.status = ST_EMPTY;
        row = '{b, 1, f}; rows.insert(rows.size(), row);
        b = '1; b.func = FUNC_ADD; b.now_ns = 63'd1000;
        f = '1; f.status = ST_OK; f.entry_count = 5'd1;
        row = '{b, 1, f}; rows.insert(rows.size(), row);
        // Backward clock and a gap too short are both gated.
        b = '0; b.func = FUNC_ADD; b.frame_width = 16'd1; b.frame_height = 16'd1;
        b.now_ns = 63'd5;
        f = '0; f.status = ST_SKIPPED; f.entry_count = 5'd1;
        row = '{b, 1, f}; rows.insert(rows.size(), row);
        b.now_ns = 63'd1001;
        row = '{b, 1, f}; rows.insert(rows.size(), row);
        b = '0; b.func = FUNC_CLEAR; f = '0; f.status = ST_OK;
        row = '{b, 1, f}; rows.insert(rows.size(), row);
        b.func = t_func'(3'd6); f.status = ST_NONE;
        row = '{b, 1, f}; rows.insert(rows.size(), row);
        b.func = t_func'(3'd7); row = '{b, 1, f}; rows.insert(rows.size(), row);
        foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_fixed, rows[i].fixed);
        drain();

        // A clear keeps the gate state, so the clock goes on from the last add;
        // an interval of zero lets adds follow one another closely.
        write_register(CFG_INTERVAL, 32'd0);
        write_register(CFG_MAX_ENTRIES, 5'd3);
        rows.delete();
        for (int i = 0; i < 5; i++) begin
            b = '1; b.func = FUNC_ADD; b.frame_time_ns = 63'(100 * i + 100);
            b.now_ns = 63'(2000 + i);
            b.frame_handle = 32'(i);
            row = '{b, 0, '0}; rows.insert(rows.size(), row);
        end
        // Ties at equal distance go to the older entry; zero and largest query time.
        b = '0; b.func = FUNC_NEAREST; b.query_time_ns = 63'd350;
        row = '{b, 0, '0}; rows.insert(rows.size(), row);
        b.query_time_ns = '0; row = '{b, 0, '0}; rows.insert(rows.size(), row);
        b.query_time_ns = TMAX; row = '{b, 0, '0}; rows.insert(rows.size(), row);
        b.func = FUNC_INDEX; b.query_index = 8'd2;
        row = '{b, 0, '0}; rows.insert(rows.size(), row);
        b.query_index = 8'hFF; row = '{b, 0, '0}; rows.insert(rows.size(), row);
        b.func = FUNC_POP; row = '{b, 0, '0}; rows.insert(rows.size(), row);
        rows.insert(rows.size(), row);
        foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_fixed, rows[i].fixed);
        drain();
        // Lowering the limit leaves excess entries until the next add.
        write_register(CFG_MAX_ENTRIES, 5'd0);
        b = '0; b.func = FUNC_LATEST; send_beat(b, 0, '0);
        b = '1; b.func = FUNC_ADD; b.now_ns = 63'd3000; send_beat(b, 0, '0);
        drain();
        write_register(CFG_MAX_ENTRIES, 5'd31);

        // Random phases with different idling and register settings.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
                1: begin in_idle_pct = 45; out_idle_pct = 0;  end
                2: begin in_idle_pct = 0;  out_idle_pct = 45; end
                default: begin in_idle_pct = 12; out_idle_pct = 12; end
            endcase
            interval_pick = $urandom_range(3);
            write_register(CFG_INTERVAL, interval_pick == 0 ? 32'd0 :
                           interval_pick == 1 ? 32'hFFFF_FFFF :
                           interval_pick == 2 ? 32'd33333333 : $urandom);
            write_register(CFG_MAX_ENTRIES, phase == 3 ? 5'd1 : phase == 5 ? 5'd16 :
                           5'($urandom_range(31)));
            // Keep time moving forward from the last add so the gate opens.
            clock_ns = sh_last_add[62] ? '0 : sh_last_add;
            for (int n = 0; n < 215; n++) begin
                if (phase == 2 && n == 10) hold_release = 1'b1;
                send_beat(random_beat(), 0, '0);
            end
            // The sender pauses here until every expected result is in.
            drain();
        end
        stim_done = 1'b1;
        repeat (5 * DEPTH) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
